### sv/shs_pkg.sv
package shs_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       last;
  } msg_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } state_t;

  // where the byte pushed into the block buffer comes from
  typedef enum logic [1:0] {
    SRC_MSG,
    SRC_MARK,
    SRC_ZERO,
    SRC_LEN
  } byte_src_t;

  typedef struct packed {
    logic      push;
    byte_src_t src;
    logic      count_bits;
    logic      round_en;
    logic [5:0] round;
    logic      fold;
    logic      emit_load;
    logic [2:0] emit_idx;
    logic      reinit;
  } cmd_t;

  typedef struct packed {
    logic [5:0] fill;
    logic       out_free;
  } status_t;

  localparam logic [7:0] PAD_MARK   = 8'h80;
  localparam logic [5:0] LEN_POS    = 6'd56;
  localparam logic [5:0] BLOCK_LAST = 6'd63;
  localparam logic [5:0] ROUND_LAST = 6'd63;
  localparam logic [2:0] WORD_LAST  = 3'd7;

  function automatic logic [31:0] iv_word(input logic [2:0] idx);
    logic [31:0] r;
    case (idx)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      3'd7: r = 32'h5be0cd19;
      default: r = 32'h6a09e667;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
      default: k = 32'h428a2f98;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

### sv/shs_ctrl.sv
module shs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              msg_valid,
  input  shs_pkg::msg_t     msg,
  output logic              msg_stall,
  input  shs_pkg::status_t  sts,
  output shs_pkg::cmd_t     cmd
);

  shs_pkg::state_t    state;
  shs_pkg::state_t    state_next;
  logic [5:0]         cnt;
  logic [5:0]         cnt_next;
  logic               first;
  logic               first_next;
  logic               len_ok;
  logic               len_ok_next;
  logic               final_blk;
  logic               final_blk_next;
  logic               pend;
  logic               pend_next;
  shs_pkg::byte_src_t pad_src;

  // marker first, zeros up to the length field, then the length bytes
  always_comb begin
    if (first) begin
      pad_src = shs_pkg::SRC_MARK;
    end else if (sts.fill >= shs_pkg::LEN_POS && len_ok) begin
      pad_src = shs_pkg::SRC_LEN;
    end else begin
      pad_src = shs_pkg::SRC_ZERO;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= shs_pkg::ST_IDLE;
      cnt       <= '0;
      first     <= 1'b0;
      len_ok    <= 1'b0;
      final_blk <= 1'b0;
      pend      <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      first     <= first_next;
      len_ok    <= len_ok_next;
      final_blk <= final_blk_next;
      pend      <= pend_next;
    end
  end

  // next state
  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    first_next     = first;
    len_ok_next    = len_ok;
    final_blk_next = final_blk;
    pend_next      = pend;
    case (state)
      shs_pkg::ST_IDLE: begin
        if (msg_valid && (msg.byte_present || msg.last)) begin
          pend_next      = msg.last;
          first_next     = msg.last;
          len_ok_next    = 1'b0;
          final_blk_next = 1'b0;
          if (msg.byte_present && sts.fill == shs_pkg::BLOCK_LAST) begin
            state_next = shs_pkg::ST_ROUND;
            cnt_next   = '0;
          end else if (msg.last) begin
            state_next = shs_pkg::ST_PAD;
          end
        end
      end
      shs_pkg::ST_PAD: begin
        if (first) begin
          first_next  = 1'b0;
          len_ok_next = sts.fill < shs_pkg::LEN_POS;
        end
        if (sts.fill == shs_pkg::BLOCK_LAST) begin
          len_ok_next    = 1'b1;
          final_blk_next = pad_src == shs_pkg::SRC_LEN;
          state_next     = shs_pkg::ST_ROUND;
          cnt_next       = '0;
        end
      end
      shs_pkg::ST_ROUND: begin
        cnt_next = cnt + 6'd1;
        if (cnt == shs_pkg::ROUND_LAST) begin
          state_next = shs_pkg::ST_FOLD;
        end
      end
      shs_pkg::ST_FOLD: begin
        cnt_next = '0;
        if (final_blk) begin
          state_next = shs_pkg::ST_EMIT;
        end else if (pend) begin
          state_next = shs_pkg::ST_PAD;
        end else begin
          state_next = shs_pkg::ST_IDLE;
        end
      end
      shs_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          if (cnt[2:0] == shs_pkg::WORD_LAST) begin
            state_next     = shs_pkg::ST_IDLE;
            cnt_next       = '0;
            pend_next      = 1'b0;
            final_blk_next = 1'b0;
          end else begin
            cnt_next = cnt + 6'd1;
          end
        end
      end
      default: begin
        state_next = shs_pkg::ST_IDLE;
      end
    endcase
  end

  // commands
  always_comb begin
    cmd        = '0;
    cmd.src    = shs_pkg::SRC_MSG;
    cmd.round  = cnt;
    cmd.emit_idx = cnt[2:0];
    msg_stall  = state != shs_pkg::ST_IDLE;
    case (state)
      shs_pkg::ST_IDLE: begin
        cmd.push       = msg_valid && msg.byte_present;
        cmd.count_bits = msg_valid && msg.byte_present;
      end
      shs_pkg::ST_PAD: begin
        cmd.push = 1'b1;
        cmd.src  = pad_src;
      end
      shs_pkg::ST_ROUND: begin
        cmd.round_en = 1'b1;
      end
      shs_pkg::ST_FOLD: begin
        cmd.fold = 1'b1;
      end
      shs_pkg::ST_EMIT: begin
        cmd.emit_load = sts.out_free;
        cmd.reinit    = sts.out_free && cnt[2:0] == shs_pkg::WORD_LAST;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  a_rounds_end: assert property (@(posedge clk) disable iff (rst)
    (state == shs_pkg::ST_ROUND && cnt == shs_pkg::ROUND_LAST) |=> state == shs_pkg::ST_FOLD)
    else $error("round sequence did not end in fold");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_load |-> sts.out_free)
    else $error("digest word loaded over a waiting one");

  a_full_block: assert property (@(posedge clk) disable iff (rst)
    (cmd.push && sts.fill == shs_pkg::BLOCK_LAST) |=> state == shs_pkg::ST_ROUND)
    else $error("full block not compressed");

  a_pad_len: assert property (@(posedge clk) disable iff (rst)
    (cmd.push && cmd.src == shs_pkg::SRC_LEN) |-> sts.fill >= shs_pkg::LEN_POS)
    else $error("length byte outside the length field");

endmodule

### sv/shs_datapath.sv
module shs_datapath (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        data_byte,
  input  shs_pkg::cmd_t     cmd,
  output shs_pkg::status_t  sts,
  input  logic              digest_stall,
  output logic              digest_valid,
  output shs_pkg::digest_t  digest
);

  logic [511:0]     blk;
  logic [5:0]       fill;
  logic [63:0]      bits;
  logic [7:0][31:0] h;
  logic [7:0][31:0] v;
  logic [7:0]       push_byte;
  logic [7:0]       len_byte;
  logic [31:0]      w0;
  logic [31:0]      w_new;
  logic [31:0]      t1;
  logic [31:0]      t2;

  // length field: most significant byte first
  assign len_byte = 8'(bits >> {~fill[2:0], 3'b000});

  always_comb begin
    case (cmd.src)
      shs_pkg::SRC_MSG:  push_byte = data_byte;
      shs_pkg::SRC_MARK: push_byte = shs_pkg::PAD_MARK;
      shs_pkg::SRC_ZERO: push_byte = 8'h00;
      shs_pkg::SRC_LEN:  push_byte = len_byte;
      default:           push_byte = 8'h00;
    endcase
  end

  // buffer holds W[t] .. W[t+15], oldest word at the top
  assign w0    = blk[511:480];
  assign w_new = shs_pkg::small_sigma1(blk[63:32]) + blk[223:192]
               + shs_pkg::small_sigma0(blk[479:448]) + w0;

  assign t1 = v[7] + shs_pkg::big_sigma1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6]))
            + shs_pkg::round_k(cmd.round) + w0;
  assign t2 = shs_pkg::big_sigma0(v[0])
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      blk <= {blk[503:0], push_byte};
    end else if (cmd.round_en) begin
      blk <= {blk[479:0], w_new};
    end
    if (cmd.push && fill == shs_pkg::BLOCK_LAST) begin
      v <= h;
    end else if (cmd.round_en) begin
      v <= {v[6:4], v[3] + t1, v[2:0], t1 + t2};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      bits <= '0;
      for (int i = 0; i < 8; i++) begin
        h[i] <= shs_pkg::iv_word(3'(i));
      end
    end else begin
      if (cmd.push) begin
        fill <= fill + 6'd1;
      end
      if (cmd.reinit) begin
        bits <= '0;
      end else if (cmd.count_bits) begin
        bits <= bits + 64'd8;
      end
      if (cmd.reinit) begin
        for (int i = 0; i < 8; i++) begin
          h[i] <= shs_pkg::iv_word(3'(i));
        end
      end else if (cmd.fold) begin
        for (int i = 0; i < 8; i++) begin
          h[i] <= h[i] + v[i];
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      digest_valid <= 1'b0;
    end else if (cmd.emit_load) begin
      digest_valid <= 1'b1;
    end else if (!digest_stall) begin
      digest_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      digest.digest_word <= h[cmd.emit_idx];
      digest.word_index  <= cmd.emit_idx;
      digest.last_word   <= cmd.emit_idx == shs_pkg::WORD_LAST;
    end
  end

  assign sts.fill     = fill;
  assign sts.out_free = !digest_valid || !digest_stall;

endmodule

### sv/sha256_stream_hasher_core.sv
// SHA-256 over a byte stream. Each msg transaction carries at most one byte;
// a transaction with last set ends the message (with or without a byte of
// its own) and yields eight digest transactions, word 0 first, after which
// the hash state is back at its initial values for the next message. When
// the 64th byte of a block lands, msg_stall goes high for the 64 rounds
// through the single round unit and the fold of the result into the
// chaining words. Finishing a message pads one byte per cycle through the
// same byte path, with an extra block when more than 55 bytes are pending;
// each padded block again goes through the rounds and the fold, and then
// the eight words leave at one per cycle while digest_stall is low.
// msg_stall is high whenever the block is busy with a block, padding or
// the digest words.
module sha256_stream_hasher_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              msg_valid,
  output logic              msg_stall,
  input  shs_pkg::msg_t     msg,
  output logic              digest_valid,
  input  logic              digest_stall,
  output shs_pkg::digest_t  digest
);

  // command and status links between sequencer and datapath
  shs_pkg::cmd_t    cmd;
  shs_pkg::status_t sts;

  // sequencer: intake, padding order, round count, digest word count
  shs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg_valid),
    .msg       (msg),
    .msg_stall (msg_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: block buffer and schedule, round unit, chaining words,
  // bit count and digest output register
  shs_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .data_byte    (msg.data_byte),
    .cmd          (cmd),
    .sts          (sts),
    .digest_stall (digest_stall),
    .digest_valid (digest_valid),
    .digest       (digest)
  );

endmodule
